### rtl/core/tpnv_pkg.sv
package tpnv_pkg;

    localparam int DIST_W        = 24;
    localparam int B_W           = 6;
    localparam int LEN_W         = 20;
    localparam int BB_W          = 2 * B_W;
    localparam int DEN_W         = 32;
    localparam int OUT_W         = 48;
    localparam int F_W           = 64;
    localparam int QUO_BITS      = 96;
    localparam int TAYLOR_TERMS  = 16;
    localparam int TERM_W        = 33;
    localparam int P_W           = 35;
    localparam int N_W           = 7;
    localparam int RECIP_SH      = 36;
    localparam int Y_SAT_SH      = 37;
    localparam int N_SAT         = 34;
    localparam int Q28_SH        = 28;
    localparam int E_SH          = 4;
    localparam int FRAC_BITS_DEF = 20;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    // L1, L2, L3, L4, L5 and L7, the series, the wide product, the second divider
    localparam int LANE_FIX_LAT  = 6 + 3 * (TAYLOR_TERMS - 1) + 3 + QUO_BITS;

    localparam logic [31:0] LOG2E_Q31 = 32'hB8AA3B29;
    localparam logic [31:0] LN2_Q32   = 32'hB17217F8;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic [B_W-1:0]   ALPHABET_RST = 6'd4;
    localparam logic [LEN_W-1:0] LENGTH_RST   = 20'd1000;

    localparam logic REG_ALPHABET_SIZE   = 1'b0;
    localparam logic REG_SEQUENCE_LENGTH = 1'b1;

    typedef struct packed {
        logic [B_W-1:0]   b_eff;
        logic [B_W-1:0]   bm1;
        logic [DEN_W-1:0] den;
    } cfg_t;

endpackage

### rtl/core/tpnv_in_if.sv
interface tpnv_in_if;
    import tpnv_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] dist_ij;
    logic [DIST_W-1:0] dist_ik;
    logic [DIST_W-1:0] dist_jk;
    logic [DIST_W-1:0] corr_i;
    logic [DIST_W-1:0] corr_j;
    logic              degenerate;

    modport source (output valid, dist_ij, dist_ik, dist_jk, corr_i, corr_j, degenerate,
                    input ready);
    modport sink   (input valid, dist_ij, dist_ik, dist_jk, corr_i, corr_j, degenerate,
                    output ready);
endinterface

### rtl/core/tpnv_out_if.sv
interface tpnv_out_if;
    import tpnv_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] noise_variance;

    modport source (output valid, noise_variance, input ready);
    modport sink   (input valid, noise_variance, output ready);
endinterface

### rtl/core/tpnv_cfg.sv
module tpnv_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpnv_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpnv_pkg::DATA_W-1:0]  pwdata,
    output logic [tpnv_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tpnv_pkg::cfg_t               cfg
);
    import tpnv_pkg::*;

    logic [B_W-1:0]   alph_reg, alph_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [B_W-1:0]   b_eff_reg, b_eff_next;
    logic [B_W-1:0]   bm1_reg, bm1_next;
    logic [BB_W-1:0]  bb_reg, bb_next;
    logic [LEN_W-1:0] len_eff_reg, len_eff_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_comb
    begin
        alph_next = alph_reg;
        len_next  = len_reg;
        if (wr)
        begin
            case (paddr[2])
                REG_ALPHABET_SIZE:   alph_next = pwdata[B_W-1:0];
                REG_SEQUENCE_LENGTH: len_next  = pwdata[LEN_W-1:0];
                default:             alph_next = alph_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ALPHABET_SIZE:   prdata = DATA_W'(alph_reg);
            REG_SEQUENCE_LENGTH: prdata = DATA_W'(len_reg);
            default:             prdata = '0;
        endcase
    end

    assign b_eff_next   = (alph_reg < B_W'(2)) ? B_W'(2) : alph_reg;
    assign bm1_next     = b_eff_reg - B_W'(1);
    assign bb_next      = BB_W'(b_eff_reg) * BB_W'(b_eff_reg);
    assign len_eff_next = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign den_next     = DEN_W'(bb_reg) * DEN_W'(len_eff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alph_reg    <= ALPHABET_RST;
            len_reg     <= LENGTH_RST;
            b_eff_reg   <= ALPHABET_RST;
            bm1_reg     <= ALPHABET_RST - B_W'(1);
            bb_reg      <= BB_W'(ALPHABET_RST) * BB_W'(ALPHABET_RST);
            len_eff_reg <= LENGTH_RST;
            den_reg     <= DEN_W'(BB_W'(ALPHABET_RST) * BB_W'(ALPHABET_RST))
                           * DEN_W'(LENGTH_RST);
        end
        else
        begin
            alph_reg    <= alph_next;
            len_reg     <= len_next;
            b_eff_reg   <= b_eff_next;
            bm1_reg     <= bm1_next;
            bb_reg      <= bb_next;
            len_eff_reg <= len_eff_next;
            den_reg     <= den_next;
        end
    end

    assign cfg.b_eff = b_eff_reg;
    assign cfg.bm1   = bm1_reg;
    assign cfg.den   = den_reg;

endmodule

### rtl/core/tpnv_div.sv
module tpnv_div #(
    parameter int NW = 44,
    parameter int DW = 6,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem0,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);
    logic [NW-1:0] word_reg [0:NW-1];
    logic [SW-1:0] side_reg [0:NW-1];
    logic [DW-1:0] rem_reg  [0:NW-2];

    genvar s;
    generate
        for (s = 0; s < NW; s++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [NW-1:0] word_in;
            logic [SW-1:0] side_stage;
            logic [DW:0]   r2;
            logic [DW:0]   diff;
            logic          ge;

            if (s == 0)
            begin : g_first
                assign rem_in     = rem0;
                assign word_in    = num;
                assign side_stage = side_in;
            end
            else
            begin : g_next
                assign rem_in     = rem_reg[s-1];
                assign word_in    = word_reg[s-1];
                assign side_stage = side_reg[s-1];
            end

            assign r2   = {rem_in, word_in[NW-1]};
            assign diff = r2 - {1'b0, den};
            assign ge   = (r2 >= {1'b0, den});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    word_reg[s] <= {word_in[NW-2:0], ge};
                    side_reg[s] <= side_stage;
                end
            end

            if (s < NW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                        rem_reg[s] <= ge ? diff[DW-1:0] : r2[DW-1:0];
                end
            end
        end
    endgenerate

    assign quo      = word_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule

### rtl/core/tpnv_lane.sv
module tpnv_lane #(
    parameter int XW = 38
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [XW-1:0]             x,
    input  tpnv_pkg::cfg_t            cfg,
    output logic [tpnv_pkg::F_W-1:0]  f,
    output logic                      sat
);
    import tpnv_pkg::*;

    localparam int NW1    = XW + B_W;
    localparam int MH_W   = 39;
    localparam int PROD_W = QUO_BITS + B_W;
    localparam int FW_W   = PROD_W - 32;
    localparam int T      = TAYLOR_TERMS;

    typedef struct packed {
        logic [31:0]    z;
        logic [N_W-1:0] n;
        logic           sat;
        logic [P_W-1:0] p;
    } tay_t;

    // L1: scale by b and flag an exponent argument of 32 or more
    logic [NW1-1:0] xb_next, xb_reg;
    logic           sat1_next, sat1_reg;

    assign xb_next   = NW1'(x) * NW1'(cfg.b_eff);
    assign sat1_next = (64'(xb_next) >= (64'(cfg.bm1) << Y_SAT_SH));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xb_reg   <= xb_next;
            sat1_reg <= sat1_next;
        end
    end

    logic [NW1-1:0] y;
    logic           sat_y;

    tpnv_div #(.NW(NW1), .DW(B_W), .SW(1)) u_div_y (
        .clk      (clk),
        .en       (en),
        .rem0     (B_W'(0)),
        .num      (xb_reg),
        .den      (cfg.bm1),
        .side_in  (sat1_reg),
        .quo      (y),
        .side_out (sat_y)
    );

    // L2: y times log2(e)
    logic [63:0]     y_ext;
    logic [MH_W-1:0] mh_reg;
    logic [63:0]     ml_reg;
    logic            sat2_reg;

    assign y_ext = 64'(y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mh_reg   <= MH_W'(y_ext[36:32]) * (MH_W'(LOG2E_Q31) << 1);
            ml_reg   <= 64'(y_ext[31:0]) * 64'(LOG2E_Q31);
            sat2_reg <= sat_y;
        end
    end

    // L3: split into integer and fraction of the power of two
    logic [MH_W-1:0] t_sum;
    logic [N_W-1:0]  n_reg;
    logic [31:0]     r_reg;
    logic            sat3_reg;

    assign t_sum = mh_reg + MH_W'(ml_reg >> 31);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= t_sum[MH_W-1:32];
            r_reg    <= t_sum[31:0];
            sat3_reg <= sat2_reg | (t_sum[MH_W-1:32] >= N_W'(N_SAT));
        end
    end

    // L4 and series: exp(z) by sixteen Taylor terms, three stages a term
    tay_t            pass_a_reg [1:T-1];
    tay_t            pass_b_reg [1:T-1];
    tay_t            pass_c_reg [0:T-1];
    logic [31:0]     v_a_reg    [1:T-1];
    logic [31:0]     v_b_reg    [1:T-1];
    logic [31:0]     q0_b_reg   [1:T-1];
    logic [TERM_W-1:0] term_c_reg [0:T-2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass_c_reg[0].z   <= 32'((64'(r_reg) * 64'(LN2_Q32)) >> 32);
            pass_c_reg[0].n   <= n_reg;
            pass_c_reg[0].sat <= sat3_reg;
            pass_c_reg[0].p   <= P_W'(1) << 32;
            term_c_reg[0]     <= TERM_W'(1) << 32;
        end
    end

    genvar k;
    generate
        for (k = 1; k < T; k++)
        begin : g_term
            localparam logic [RECIP_SH:0] RECIP = (RECIP_SH+1)'((64'd1 << RECIP_SH) / k);
            logic [35:0] rem;
            logic [31:0] q;

            assign rem = 36'(v_b_reg[k]) - 36'(q0_b_reg[k]) * 36'(k);
            assign q   = (rem >= 36'(k)) ? q0_b_reg[k] + 32'd1 : q0_b_reg[k];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_a_reg[k]    <= 32'((65'(term_c_reg[k-1]) * 65'(pass_c_reg[k-1].z))
                                         >> 32);
                    pass_a_reg[k] <= pass_c_reg[k-1];
                    q0_b_reg[k]   <= 32'((69'(v_a_reg[k]) * 69'(RECIP)) >> RECIP_SH);
                    v_b_reg[k]    <= v_a_reg[k];
                    pass_b_reg[k] <= pass_a_reg[k];
                    pass_c_reg[k].z   <= pass_b_reg[k].z;
                    pass_c_reg[k].n   <= pass_b_reg[k].n;
                    pass_c_reg[k].sat <= pass_b_reg[k].sat;
                    pass_c_reg[k].p   <= pass_b_reg[k].p + P_W'(q);
                end
            end

            if (k < T - 1)
            begin : g_keep
                always_ff @(posedge clk)
                begin
                    if (en)
                        term_c_reg[k] <= TERM_W'(q);
                end
            end
        end
    endgenerate

    // L5: scale by 2^n into Q28, subtract one
    logic [63:0] e_val, u_next, ub_next;
    logic [63:0] u_reg, ub_reg;
    logic        sat5_reg;

    always_comb
    begin
        if (pass_c_reg[T-1].n >= N_W'(E_SH))
            e_val = 64'(pass_c_reg[T-1].p) << (pass_c_reg[T-1].n - N_W'(E_SH));
        else
            e_val = 64'(pass_c_reg[T-1].p) >> (N_W'(E_SH) - pass_c_reg[T-1].n);
    end

    assign u_next  = e_val - (64'd1 << Q28_SH);
    assign ub_next = u_next + (64'(cfg.b_eff) << Q28_SH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            ub_reg   <= ub_next;
            sat5_reg <= pass_c_reg[T-1].sat;
        end
    end

    // M1..M3: u * (u + b), 64 by 64 in four partial products
    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg, ll2_reg, lh2_reg;
    logic [31:0]  uh_reg, ubl_reg, ubh_reg;
    logic         satm1_reg, satm2_reg, satm3_reg;
    logic [127:0] num_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg    <= 64'(u_reg[31:0]) * 64'(ub_reg[31:0]);
            lh_reg    <= 64'(u_reg[31:0]) * 64'(ub_reg[63:32]);
            uh_reg    <= u_reg[63:32];
            ubl_reg   <= ub_reg[31:0];
            ubh_reg   <= ub_reg[63:32];
            satm1_reg <= sat5_reg;

            hl_reg    <= 64'(uh_reg) * 64'(ubl_reg);
            hh_reg    <= 64'(uh_reg) * 64'(ubh_reg);
            ll2_reg   <= ll_reg;
            lh2_reg   <= lh_reg;
            satm2_reg <= satm1_reg;

            num_reg   <= 128'(ll2_reg) + (128'(lh2_reg) << 32) + (128'(hl_reg) << 32)
                         + (128'(hh_reg) << 64);
            satm3_reg <= satm2_reg;
        end
    end

    logic [QUO_BITS-1:0] q_val;
    logic                sat_q;
    logic                sat_div_in;

    assign sat_div_in = satm3_reg | (num_reg[127:QUO_BITS] >= cfg.den);

    tpnv_div #(.NW(QUO_BITS), .DW(DEN_W), .SW(1)) u_div_q (
        .clk      (clk),
        .en       (en),
        .rem0     (num_reg[127:QUO_BITS]),
        .num      (num_reg[QUO_BITS-1:0]),
        .den      (cfg.den),
        .side_in  (sat_div_in),
        .quo      (q_val),
        .side_out (sat_q)
    );

    // L7: times (b-1), back to Q24
    logic [PROD_W-1:0] prod;
    logic [FW_W-1:0]   fw;
    logic [F_W-1:0]    f_reg;
    logic              sat7_reg;

    assign prod = PROD_W'(q_val) * PROD_W'(cfg.bm1);
    assign fw   = prod[PROD_W-1:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg    <= fw[F_W-1:0];
            sat7_reg <= sat_q | (fw[FW_W-1:F_W] != '0);
        end
    end

    assign f   = f_reg;
    assign sat = sat7_reg;

endmodule

### rtl/core/three_point_noise_variance.sv
// Streams one word per clock with full throughput: a new distance triple can be
// taken every cycle while earlier ones are in flight, and a stall on the result
// side holds the whole pipeline in place. Each evaluation lane holds two
// long-division pipelines (one quotient bit a stage: XW+6 bits for the scaling
// by b/(b-1), 96 bits for the division by b*b*L, with XW = 58 - FRAC_BITS) and
// the sixteen-term Taylor series for the exponential at three stages for each
// term after the first. Three lanes evaluate the total variance at the three
// points side by side. Derived register values settle after an APB write through
// the registered chain of effective alphabet size and length, then b-1 and b*b,
// then the denominator.
module three_point_noise_variance #(
    parameter int FRAC_BITS = tpnv_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tpnv_in_if.sink                      in_ch,
    tpnv_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpnv_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpnv_pkg::DATA_W-1:0]  pwdata,
    output logic [tpnv_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import tpnv_pkg::*;

    localparam int SH       = 32 - FRAC_BITS;
    localparam int DWID     = DIST_W + SH;
    localparam int XW       = DWID + 2;
    localparam int LANE_LAT = XW + B_W + LANE_FIX_LAT;
    localparam int PIPE     = LANE_LAT + 5;

    cfg_t cfg;

    tpnv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic en;
    logic out_vld_reg;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic vld_pipe_reg [0:PIPE-1];
    logic deg_pipe_reg [0:PIPE-1];

    assign en          = ~out_vld_reg | out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE; i++)
                vld_pipe_reg[i] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_pipe_reg[0] <= in_ch.valid;
            for (int i = 1; i < PIPE; i++)
                vld_pipe_reg[i] <= vld_pipe_reg[i-1];
            out_vld_reg <= vld_pipe_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_pipe_reg[0] <= in_ch.degenerate;
            for (int i = 1; i < PIPE; i++)
                deg_pipe_reg[i] <= deg_pipe_reg[i-1];
        end
    end

    // S0: move to Q.32
    logic [DWID-1:0] ij0_reg, ik0_reg, jk0_reg, ci0_reg, cj0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ij0_reg <= DWID'(in_ch.dist_ij) << SH;
            ik0_reg <= DWID'(in_ch.dist_ik) << SH;
            jk0_reg <= DWID'(in_ch.dist_jk) << SH;
            ci0_reg <= DWID'(in_ch.corr_i) << SH;
            cj0_reg <= DWID'(in_ch.corr_j) << SH;
        end
    end

    // S1: triangle tests
    logic [DWID:0]   sum_ab;
    logic [DWID:0]   sum_ab_reg;
    logic [DWID-1:0] ij1_reg, ik1_reg, jk1_reg, ci1_reg, cj1_reg;
    logic            c_jk_reg, c_ij_reg, c_ik_reg;
    logic [XW-1:0]   x1_1_reg;

    assign sum_ab = (DWID+1)'(ij0_reg) + (DWID+1)'(ik0_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_ab_reg <= sum_ab;
            c_jk_reg   <= (DWID+1)'(jk0_reg) > sum_ab;
            c_ij_reg   <= (DWID+1)'(ij0_reg) > ((DWID+1)'(ik0_reg) + (DWID+1)'(jk0_reg));
            c_ik_reg   <= (DWID+1)'(ik0_reg) > ((DWID+1)'(ij0_reg) + (DWID+1)'(jk0_reg));
            x1_1_reg   <= XW'(ij0_reg) + XW'(ci0_reg) + XW'(cj0_reg);
            ij1_reg    <= ij0_reg;
            ik1_reg    <= ik0_reg;
            jk1_reg    <= jk0_reg;
            ci1_reg    <= ci0_reg;
            cj1_reg    <= cj0_reg;
        end
    end

    // S2: place the branch point
    logic [DWID:0]   half_diff;
    logic [DWID-1:0] dil_next, dil_reg, ij2_reg, ci2_reg, cj2_reg;
    logic [XW-1:0]   x1_2_reg;

    assign half_diff = (sum_ab_reg - (DWID+1)'(jk1_reg)) >> 1;

    always_comb
    begin
        if (c_jk_reg)
            dil_next = '0;
        else if (c_ij_reg)
            dil_next = ik1_reg;
        else if (c_ik_reg)
            dil_next = ij1_reg;
        else
            dil_next = half_diff[DWID-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dil_reg  <= dil_next;
            ij2_reg  <= ij1_reg;
            ci2_reg  <= ci1_reg;
            cj2_reg  <= cj1_reg;
            x1_2_reg <= x1_1_reg;
        end
    end

    // S3: the three evaluation points
    logic [XW-1:0] x_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x1_2_reg;
            x_reg[1] <= XW'(dil_reg) + XW'(ci2_reg);
            x_reg[2] <= XW'(ij2_reg) - XW'(dil_reg) + XW'(cj2_reg);
        end
    end

    logic [F_W-1:0] f_l   [0:2];
    logic           sat_l [0:2];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            tpnv_lane #(.XW(XW)) u_lane (
                .clk (clk),
                .en  (en),
                .x   (x_reg[g]),
                .cfg (cfg),
                .f   (f_l[g]),
                .sat (sat_l[g])
            );
        end
    endgenerate

    // F1: first difference
    logic [F_W-1:0] d12_reg, f3_reg;
    logic           ok_reg, s1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d12_reg <= f_l[0] - f_l[1];
            ok_reg  <= ~sat_l[1] & ~sat_l[2] & (f_l[1] <= f_l[0]);
            f3_reg  <= f_l[2];
            s1_reg  <= sat_l[0];
        end
    end

    // F2: second difference, clamp
    logic [F_W-1:0] diff;

    assign diff = d12_reg - f3_reg;

    always_comb
    begin
        if (deg_pipe_reg[PIPE-1])
            out_data_next = '0;
        else if (s1_reg)
            out_data_next = OUT_MAX;
        else if (ok_reg && (f3_reg <= d12_reg))
            out_data_next = (diff > F_W'(OUT_MAX)) ? OUT_MAX : diff[OUT_W-1:0];
        else
            out_data_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.noise_variance = out_data_reg;

endmodule

### sim/tb_three_point_noise_variance.sv
module tb_three_point_noise_variance;
    import tpnv_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int HOLD_LEN  = 600;
    localparam int WD_LIMIT  = 4000;
    localparam int DRAIN_CYC = 2 * (32 - FRAC) + 200;

    typedef struct packed {
        logic [DIST_W-1:0] dist_ij;
        logic [DIST_W-1:0] dist_ik;
        logic [DIST_W-1:0] dist_jk;
        logic [DIST_W-1:0] corr_i;
        logic [DIST_W-1:0] corr_j;
        logic              degenerate;
    } triple_t;

    typedef struct packed {
        triple_t          word;
        logic             fixed;
        logic [OUT_W-1:0] value;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    tpnv_in_if  in_ch();
    tpnv_out_if out_ch();

    three_point_noise_variance #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [B_W-1:0]   alpha_cfg = ALPHABET_RST;
    logic [LEN_W-1:0] length_cfg = LENGTH_RST;
    logic [OUT_W-1:0] variance_q[$];
    int src_idle = 0;
    int snk_stall = 0;
    int hold_start = 0;
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int n_sat = 0;
    int n_zero = 0;
    int idle_cyc = 0;

    function automatic logic [63:0] total_var(input logic [63:0] x, input logic [63:0] b,
                                              input logic [63:0] len, output logic sat);
        logic [63:0] y, yi, yf, t, n, r, z, term, p, e, u, den, a, part;
        logic [127:0] num, quo, fw;
        sat = 1'b0;
        y = (x * b) / (b - 64'd1);
        yi = y >> 32;
        yf = {32'd0, y[31:0]};
        if (yi >= 64'd32)
        begin
            sat = 1'b1;
            return '1;
        end
        t = yi * (64'd2 * {32'd0, LOG2E_Q31}) + ((yf * {32'd0, LOG2E_Q31}) >> 31);
        n = t >> 32;
        r = {32'd0, t[31:0]};
        if (n >= N_SAT)
        begin
            sat = 1'b1;
            return '1;
        end
        z = (r * {32'd0, LN2_Q32}) >> 32;
        term = 64'd1 << 32;
        p = term;
        for (int k = 1; k < TAYLOR_TERMS; k++)
        begin
            term = ((term * z) >> 32) / k;
            p = p + term;
        end
        e = (n >= 64'd4) ? (p << (n - 64'd4)) : (p >> (64'd4 - n));
        u = e - (64'd1 << 28);
        num = {64'd0, u} * {64'd0, u + (b << 28)};
        den = b * b * len;
        quo = num / {64'd0, den};
        if (quo[127:96] != 0)
        begin
            sat = 1'b1;
            return '1;
        end
        a = quo[95:32];
        part = ({32'd0, quo[31:0]} * (b - 64'd1)) >> 32;
        fw = {64'd0, a} * {64'd0, b - 64'd1} + {64'd0, part};
        if (fw[127:64] != 0)
        begin
            sat = 1'b1;
            return '1;
        end
        return fw[63:0];
    endfunction

    function automatic logic [OUT_W-1:0] noise_of(input triple_t w);
        logic [63:0] ij, ik, jk, ci, cj, dil, dlj, b, len, f1, f2, f3, res;
        logic s1, s2, s3;
        if (w.degenerate)
            return '0;
        ij = {40'd0, w.dist_ij} << (32 - FRAC);
        ik = {40'd0, w.dist_ik} << (32 - FRAC);
        jk = {40'd0, w.dist_jk} << (32 - FRAC);
        ci = {40'd0, w.corr_i} << (32 - FRAC);
        cj = {40'd0, w.corr_j} << (32 - FRAC);
        if (jk > ij + ik)
            dil = '0;
        else if (ij > ik + jk)
            dil = ik;
        else if (ik > ij + jk)
            dil = ij;
        else
            dil = (ij + ik - jk) >> 1;
        dlj = ij - dil;
        b = (alpha_cfg < 2) ? 64'd2 : {58'd0, alpha_cfg};
        len = (length_cfg == 0) ? 64'd1 : {44'd0, length_cfg};
        f1 = total_var(ij + ci + cj, b, len, s1);
        if (s1)
            return OUT_MAX;
        f2 = total_var(dil + ci, b, len, s2);
        f3 = total_var(dlj + cj, b, len, s3);
        res = '0;
        if (!s2 && !s3 && f2 <= f1 && f3 <= f1 - f2)
            res = f1 - f2 - f3;
        if (res > {16'd0, OUT_MAX})
            res = {16'd0, OUT_MAX};
        return res[OUT_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] rand_dist();
        int w;
        w = $urandom_range(DIST_W);
        if ($urandom_range(9) == 0)
            return DIST_W'($urandom);
        return DIST_W'($urandom) & DIST_W'((64'd1 << w) - 1);
    endfunction

    function automatic triple_t rand_word();
        triple_t w;
        w.dist_ij = rand_dist();
        w.dist_ik = rand_dist();
        w.dist_jk = rand_dist();
        w.corr_i = rand_dist();
        w.corr_j = rand_dist();
        w.degenerate = ($urandom_range(9) == 0);
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (hold_start == 1)
        begin
            hold_start = 2;
            out_ch.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clk);
        end
        else if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= snk_stall);
        else
            out_ch.ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WD_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WD_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            words_out++;
            if (variance_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", out_ch.noise_variance);
            end
            else
            begin
                if (out_ch.noise_variance !== variance_q[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("noise_variance mismatch: expected %h, got %h",
                                 variance_q[0], out_ch.noise_variance);
                end
                if (variance_q[0] == OUT_MAX)
                    n_sat++;
                if (variance_q[0] == 0)
                    n_zero++;
                void'(variance_q.pop_front());
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] len);
        apb_write(ADDR_W'(4 * REG_ALPHABET_SIZE), b);
        alpha_cfg = b[B_W-1:0];
        apb_write(ADDR_W'(4 * REG_SEQUENCE_LENGTH), len);
        length_cfg = len[LEN_W-1:0];
        repeat (4) @(posedge clk);
    endtask

    task automatic send(input triple_t w, input logic fixed, input logic [OUT_W-1:0] val);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.dist_ij <= w.dist_ij;
        in_ch.dist_ik <= w.dist_ik;
        in_ch.dist_jk <= w.dist_jk;
        in_ch.corr_i <= w.corr_i;
        in_ch.corr_j <= w.corr_j;
        in_ch.degenerate <= w.degenerate;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        variance_q.push_back(fixed ? val : noise_of(w));
        words_in++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (variance_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int si, input int ss,
                                input bit pressure);
        src_idle = si;
        snk_stall = ss;
        for (int i = 0; i < count; i++)
        begin
            if (pressure && i == 20)
                hold_start = 1;
            send(rand_word(), 1'b0, '0);
        end
        drain();
    endtask

    row_t table_rows[$];

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.dist_ij = '0;
        in_ch.dist_ik = '0;
        in_ch.dist_jk = '0;
        in_ch.corr_i = '0;
        in_ch.corr_j = '0;
        in_ch.degenerate = 1'b0;

        table_rows.push_back('{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0}, 1'b1, '0});
        table_rows.push_back('{'{'1, '1, '1, '1, '1, 1'b1}, 1'b1, '0});
        table_rows.push_back('{'{'1, '1, '1, '1, '1, 1'b0}, 1'b1, OUT_MAX});
        table_rows.push_back('{'{'1, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0}, 1'b1, OUT_MAX});
        table_rows.push_back('{'{24'd0, 24'd0, 24'd0, '1, '1, 1'b0}, 1'b1, OUT_MAX});
        table_rows.push_back('{'{24'h100000, 24'h080000, 24'h040000, 24'h010000,
                                 24'h020000, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h040000, 24'h100000, 24'h080000, 24'h010000,
                                 24'h020000, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h040000, 24'h080000, 24'h100000, 24'h010000,
                                 24'h020000, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h0C0000, 24'h080000, 24'h060000, 24'h008000,
                                 24'h004000, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h000001, 24'h000001, 24'h000001, 24'h000001,
                                 24'h000001, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h000000, 24'h200000, 24'h200000, 24'h200000,
                                 24'h200000, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h300000, 24'h180000, 24'h180000, 24'h000000,
                                 24'h000000, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                                 24'h555555, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h2AAAAA, 24'h155555, 24'h2AAAAA, 24'h155555,
                                 24'h0AAAAA, 1'b0}, 1'b0, '0});
        table_rows.push_back('{'{24'h180000, 24'h100000, 24'h100000, 24'h100000,
                                 24'h100000, 1'b0}, 1'b0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        foreach (table_rows[i])
            send(table_rows[i].word, table_rows[i].fixed, table_rows[i].value);
        drain();
        random_phase(200, 0, 0, 1'b0);

        configure(32'd2, 32'd1);
        random_phase(230, 63, 0, 1'b0);
        configure(32'd32, 32'd1048575);
        random_phase(230, 0, 63, 1'b0);
        configure(32'd0, 32'd0);
        random_phase(230, 20, 20, 1'b0);
        configure(32'd1, 32'd500);
        random_phase(230, 0, 0, 1'b1);
        configure($urandom_range(32, 2), $urandom_range(1048575, 1));
        random_phase(230, 20, 20, 1'b0);

        repeat (DRAIN_CYC) @(posedge clk);
        if (variance_q.size() != 0)
        begin
            errors++;
            $display("%0d results never arrived", variance_q.size());
        end
        $display("%0d words in, %0d results out over six register settings", words_in,
                 words_out);
        $display("%0d saturated, %0d zero, %0d errors", n_sat, n_zero, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### three_point_noise_variance.f
rtl/core/tpnv_pkg.sv
rtl/core/tpnv_in_if.sv
rtl/core/tpnv_out_if.sv
rtl/core/tpnv_cfg.sv
rtl/core/tpnv_div.sv
rtl/core/tpnv_lane.sv
rtl/core/three_point_noise_variance.sv
sim/tb_three_point_noise_variance.sv
